// ===== src/directional_nearest_select_core_assert.svh =====
// Assertion shorthands for the directional nearest select core.
// The including module supplies clk and arst_n.
`ifndef DIRECTIONAL_NEAREST_SELECT_CORE_ASSERT_SVH
`define DIRECTIONAL_NEAREST_SELECT_CORE_ASSERT_SVH

// Same-cycle implication.
`define DNS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("directional_nearest_select_core: check failed");

// Next-cycle implication.
`define DNS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("directional_nearest_select_core: check failed");

`endif

// ===== src/dns_pkg.sv =====
`timescale 1ns / 1ps

package dns_pkg;

	localparam int MaxElements = 256;

	localparam int CoordW = 16;
	localparam int IdxW   = 8;
	localparam int Cen2W  = CoordW + 2;
	localparam int DiffW  = Cen2W + 1;
	localparam int OffW   = 18;
	localparam int SqW    = 2 * OffW;
	localparam int DistW  = 38;

	// result queue; depth must stay a power of two so the pointers wrap
	localparam int FifoDepth = 4;
	localparam int FifoAw    = $clog2(FifoDepth);
	localparam int FifoCntW  = $clog2(FifoDepth + 1);

	typedef enum logic [1:0] {
		DIR_LEFT  = 2'd0,
		DIR_RIGHT = 2'd1,
		DIR_UP    = 2'd2,
		DIR_DOWN  = 2'd3
	} dir_t;

	typedef enum logic [1:0] {
		ST_FOUND     = 2'd0,
		ST_NO_ORIGIN = 2'd1,
		ST_NONE      = 2'd2
	} status_t;

	// candidate after geometry, before the squares are summed
	typedef struct packed {
		logic            start;
		logic            last;
		logic            ok;
		logic            qual;
		logic            outside;
		logic [OffW-1:0] cross_off;
		logic [OffW-1:0] fwd;
		logic [IdxW-1:0] idx;
	} cand_t;

	typedef struct packed {
		status_t         status;
		logic [IdxW-1:0] index;
	} result_t;

endpackage

// ===== src/dns_front.sv =====
`timescale 1ns / 1ps

module dns_front import dns_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     accept,
	input  logic                     action,
	input  logic [1:0]               direction,
	input  logic signed [CoordW-1:0] rect_x,
	input  logic signed [CoordW-1:0] rect_y,
	input  logic [CoordW-1:0]        rect_w,
	input  logic [CoordW-1:0]        rect_h,
	input  logic [IdxW-1:0]          element_index,
	input  logic                     eligible,
	input  logic                     last,
	output logic                     last_busy_s1,
	output logic                     last_busy_s2,
	output logic                     valid_s2,
	output cand_t                    cand_s2,
	output logic [SqW-1:0]           fwd_sq_s2,
	output logic [SqW-1:0]           cross_sq_s2
);

	logic                     valid_s1;
	logic                     action_s1;
	logic [1:0]               dir_s1;
	logic signed [CoordW-1:0] x_s1;
	logic signed [CoordW-1:0] y_s1;
	logic [CoordW-1:0]        w_s1;
	logic [CoordW-1:0]        h_s1;
	logic [IdxW-1:0]          idx_s1;
	logic                     elig_s1;
	logic                     last_s1;

	logic signed [Cen2W-1:0] ocx2_q;
	logic signed [Cen2W-1:0] ocy2_q;
	logic                    origin_ok_q;
	dir_t                    nav_dir_q;

	logic signed [Cen2W-1:0] cx2;
	logic signed [Cen2W-1:0] cy2;
	logic signed [DiffW-1:0] dx;
	logic signed [DiffW-1:0] dy;
	logic signed [DiffW-1:0] fwd_s;
	logic signed [DiffW-1:0] cross_s;
	logic signed [DiffW-1:0] cross_abs;
	logic                    ahead;
	logic                    in_range;
	cand_t                   cand;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= action;
			dir_s1    <= direction;
			x_s1      <= rect_x;
			y_s1      <= rect_y;
			w_s1      <= rect_w;
			h_s1      <= rect_h;
			idx_s1    <= element_index;
			elig_s1   <= eligible;
			last_s1   <= last;
		end
	end

	// doubled centers
	always_comb begin
		cx2 = $signed({x_s1[CoordW-1], x_s1, 1'b0}) + $signed({2'b00, w_s1});
		cy2 = $signed({y_s1[CoordW-1], y_s1, 1'b0}) + $signed({2'b00, h_s1});
		dx  = $signed({cx2[Cen2W-1], cx2}) - $signed({ocx2_q[Cen2W-1], ocx2_q});
		dy  = $signed({cy2[Cen2W-1], cy2}) - $signed({ocy2_q[Cen2W-1], ocy2_q});
	end

	// project onto the navigation axis
	always_comb begin
		case (nav_dir_q)
			DIR_LEFT: begin
				fwd_s   = -dx;
				cross_s = dy;
			end
			DIR_RIGHT: begin
				fwd_s   = dx;
				cross_s = dy;
			end
			DIR_UP: begin
				fwd_s   = -dy;
				cross_s = dx;
			end
			default: begin
				fwd_s   = dy;
				cross_s = dx;
			end
		endcase
	end

	always_comb begin
		cross_abs      = cross_s[DiffW-1] ? -cross_s : cross_s;
		ahead          = !fwd_s[DiffW-1] && (fwd_s != '0);
		in_range       = 32'(idx_s1) < MaxElements;
		cand.start     = !action_s1;
		cand.last      = last_s1;
		cand.ok        = action_s1 ? origin_ok_q : elig_s1;
		cand.qual      = action_s1 && origin_ok_q && elig_s1 && in_range && ahead;
		cand.fwd       = fwd_s[OffW-1:0];
		cand.cross_off = cross_abs[OffW-1:0];
		cand.outside   = cand.cross_off > cand.fwd;
		cand.idx       = idx_s1;
	end

	// origin load on a start request, drop it once the request ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ocx2_q      <= '0;
			ocy2_q      <= '0;
			origin_ok_q <= 1'b0;
			nav_dir_q   <= DIR_LEFT;
		end else if (valid_s1) begin
			if (!action_s1) begin
				ocx2_q      <= cx2;
				ocy2_q      <= cy2;
				origin_ok_q <= elig_s1;
				nav_dir_q   <= dir_t'(dir_s1);
			end
			if (last_s1) begin
				origin_ok_q <= 1'b0;
			end
		end
	end

	// squares
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			cand_s2     <= cand;
			fwd_sq_s2   <= SqW'(cand.fwd) * SqW'(cand.fwd);
			cross_sq_s2 <= SqW'(cand.cross_off) * SqW'(cand.cross_off);
		end
	end

	assign last_busy_s1 = valid_s1 && last_s1;
	assign last_busy_s2 = valid_s2 && cand_s2.last;

endmodule

// ===== src/dns_rank.sv =====
`timescale 1ns / 1ps

module dns_rank import dns_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid_s2,
	input  cand_t          cand_s2,
	input  logic [SqW-1:0] fwd_sq_s2,
	input  logic [SqW-1:0] cross_sq_s2,
	output logic           last_busy_s3,
	output logic           push,
	output result_t        result
);

	localparam int KeyW = 1 + DistW + 2 * OffW + IdxW;

	logic             valid_s3;
	cand_t            cand_s3;
	logic [DistW-1:0] dist_s3;

	logic             have_best_q;
	logic             best_outside_q;
	logic [DistW-1:0] best_dist_q;
	logic [OffW-1:0]  best_cross_q;
	logic [OffW-1:0]  best_fwd_q;
	logic [IdxW-1:0]  best_idx_q;

	logic [KeyW-1:0]  cand_key;
	logic [KeyW-1:0]  best_key;
	logic             take;
	logic             res_have;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			cand_s3 <= cand_s2;
			dist_s3 <= DistW'(fwd_sq_s2) + DistW'(cross_sq_s2);
		end
	end

	// lexicographic rank: cone, distance, cross, forward, index
	always_comb begin
		cand_key = {cand_s3.outside, dist_s3, cand_s3.cross_off, cand_s3.fwd, cand_s3.idx};
		best_key = {best_outside_q, best_dist_q, best_cross_q, best_fwd_q, best_idx_q};
		take     = valid_s3 && cand_s3.qual && (!have_best_q || (cand_key < best_key));
		res_have = take || (have_best_q && !cand_s3.start);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_best_q <= 1'b0;
		end else if (valid_s3) begin
			if (cand_s3.start || cand_s3.last) begin
				have_best_q <= 1'b0;
			end else if (take) begin
				have_best_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_outside_q <= cand_s3.outside;
			best_dist_q    <= dist_s3;
			best_cross_q   <= cand_s3.cross_off;
			best_fwd_q     <= cand_s3.fwd;
			best_idx_q     <= cand_s3.idx;
		end
	end

	always_comb begin
		push         = valid_s3 && cand_s3.last;
		last_busy_s3 = push;
		result.index = '0;
		if (!cand_s3.ok) begin
			result.status = ST_NO_ORIGIN;
		end else if (!res_have) begin
			result.status = ST_NONE;
		end else begin
			result.status = ST_FOUND;
			result.index  = take ? cand_s3.idx : best_idx_q;
		end
	end

endmodule

// ===== src/dns_fifo.sv =====
`timescale 1ns / 1ps

module dns_fifo import dns_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  result_t             push_data,
	input  logic                pop,
	output logic                not_empty,
	output result_t             head,
	output logic [FifoCntW-1:0] count
);

	result_t               fifo_q [FifoDepth];
	logic [FifoAw-1:0]     wr_q;
	logic [FifoAw-1:0]     rd_q;
	logic [FifoCntW-1:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + FifoCntW'(push) - FifoCntW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= push_data;
		end
	end

	assign not_empty = cnt_q != '0;
	assign head      = fifo_q[rd_q];
	assign count     = cnt_q;

endmodule

// ===== src/directional_nearest_select_core.sv =====
`timescale 1ns / 1ps
// Directional nearest select core.
// Input channel (in_valid / in_stall) takes one rectangle request per cycle: an origin
// request (action 0) opens a navigation request and carries the direction, then candidate
// requests (action 1) follow; the request with last set closes it and yields one result.
// Output channel (out_valid / out_stall) carries status and chosen_index for each
// closed navigation request, in order.
// Throughput: one request per cycle while in_stall is low, through the three-stage
// pipeline (input register, squaring multipliers, distance sum with running-best compare).
// The pipeline never stops. Results land in a four-entry queue; in_stall rises only
// when results already queued plus closing requests still in the pipe fill that queue,
// so a stalled receiver holds its result steady while candidates keep flowing.
// Reset clears the pipeline, the origin, the running best and the queue; the first
// request after reset should be an origin, otherwise the close answers status 1.
`include "directional_nearest_select_core_assert.svh"

module directional_nearest_select_core import dns_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     action,
	input  logic [1:0]               direction,
	input  logic signed [CoordW-1:0] rect_x,
	input  logic signed [CoordW-1:0] rect_y,
	input  logic [CoordW-1:0]        rect_w,
	input  logic [CoordW-1:0]        rect_h,
	input  logic [IdxW-1:0]          element_index,
	input  logic                     eligible,
	input  logic                     last,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [1:0]               status,
	output logic [IdxW-1:0]          chosen_index
);

	logic                accept;
	logic                last_busy_s1;
	logic                last_busy_s2;
	logic                last_busy_s3;
	logic                valid_s2;
	cand_t               cand_s2;
	logic [SqW-1:0]      fwd_sq_s2;
	logic [SqW-1:0]      cross_sq_s2;
	logic                push;
	result_t             result;
	logic                pop;
	result_t             head;
	logic [FifoCntW-1:0] count;
	logic [FifoCntW-1:0] pending;

	// every closing request in flight has a queue slot reserved for it
	assign pending = count + FifoCntW'(last_busy_s1) + FifoCntW'(last_busy_s2)
		+ FifoCntW'(last_busy_s3);
	assign in_stall = pending >= FifoCntW'(FifoDepth);
	assign accept   = in_valid && !in_stall;
	assign pop      = out_valid && !out_stall;

	dns_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.action        (action),
		.direction     (direction),
		.rect_x        (rect_x),
		.rect_y        (rect_y),
		.rect_w        (rect_w),
		.rect_h        (rect_h),
		.element_index (element_index),
		.eligible      (eligible),
		.last          (last),
		.last_busy_s1  (last_busy_s1),
		.last_busy_s2  (last_busy_s2),
		.valid_s2      (valid_s2),
		.cand_s2       (cand_s2),
		.fwd_sq_s2     (fwd_sq_s2),
		.cross_sq_s2   (cross_sq_s2)
	);

	dns_rank u_rank (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s2     (valid_s2),
		.cand_s2      (cand_s2),
		.fwd_sq_s2    (fwd_sq_s2),
		.cross_sq_s2  (cross_sq_s2),
		.last_busy_s3 (last_busy_s3),
		.push         (push),
		.result       (result)
	);

	dns_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (result),
		.pop       (pop),
		.not_empty (out_valid),
		.head      (head),
		.count     (count)
	);

	assign status       = head.status;
	assign chosen_index = head.index;

	// a closing request reaches the queue once it has passed the s1, s2 and s3 registers
	`DNS_ASSERT_NOW(a_close_to_push, $past(arst_n, 1) && $past(arst_n, 2) && $past(arst_n, 3) && $past(accept && last, 3), push)
	// the queue never takes a result it has no room for
	`DNS_ASSERT_NOW(a_no_overflow, push, (count < FifoCntW'(FifoDepth)) || pop)
	// only a found result carries an index
	`DNS_ASSERT_NOW(a_index_zero, out_valid && (status != ST_FOUND), chosen_index == '0)
	// a taken result leaves the queue one entry shorter unless another lands
	`DNS_ASSERT_NEXT(a_pop_drains, pop && !push, count == ($past(count) - 1'b1))

endmodule
